[src/sixteen_bit_isa_execute_step_defines.svh]
// assertion macros used by the execute step design file
`ifndef SIXTEEN_BIT_ISA_EXECUTE_STEP_DEFINES_SVH
`define SIXTEEN_BIT_ISA_EXECUTE_STEP_DEFINES_SVH

// implication checked every clock, quiet during reset
`define SIE_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication checked every clock, quiet during reset
`define SIE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[src/sie_pkg.sv]
package sie_pkg;

  localparam int unsigned MEM_WORDS_DEFAULT = 65536;

  localparam logic [15:0] PC_RESET  = 16'h8200;
  localparam logic [2:0]  NZP_NEG   = 3'd4;
  localparam logic [2:0]  NZP_ZERO  = 3'd2;
  localparam logic [2:0]  NZP_POS   = 3'd1;

  localparam logic [3:0] OPC_BR     = 4'h0;
  localparam logic [3:0] OPC_ARITH  = 4'h1;
  localparam logic [3:0] OPC_CMP    = 4'h2;
  localparam logic [3:0] OPC_JSR    = 4'h4;
  localparam logic [3:0] OPC_LOGIC  = 4'h5;
  localparam logic [3:0] OPC_LDR    = 4'h6;
  localparam logic [3:0] OPC_STR    = 4'h7;
  localparam logic [3:0] OPC_RTI    = 4'h8;
  localparam logic [3:0] OPC_CONST  = 4'h9;
  localparam logic [3:0] OPC_SHIFT  = 4'hA;
  localparam logic [3:0] OPC_JMP    = 4'hC;
  localparam logic [3:0] OPC_HICON  = 4'hD;
  localparam logic [3:0] OPC_TRAP   = 4'hF;
  localparam logic [3:0] OPC_BAD3 = 4'h3, OPC_BADB = 4'hB, OPC_BADE = 4'hE;

  // sub-operation codes inside the arith, logic and shift groups
  localparam logic [1:0] AR_ADD = 2'd0, AR_MUL = 2'd1, AR_SUB = 2'd2, AR_DIV = 2'd3;
  localparam logic [1:0] LG_AND = 2'd0, LG_NOT = 2'd1, LG_OR = 2'd2, LG_XOR = 2'd3;
  localparam logic [1:0] SH_SLL = 2'd0, SH_SRA = 2'd1, SH_SRL = 2'd2, SH_MOD = 2'd3;

  typedef struct packed {
    logic [15:0] pc_before;
    logic        reg_we;
    logic [2:0]  reg_dest;
    logic [15:0] reg_value;
    logic        nzp_we;
    logic [2:0]  nzp_value;
    logic        data_we;
    logic [15:0] data_addr;
    logic [15:0] data_value;
    logic        invalid;
    logic        privileged;
  } trace_t;

  // divider request / response between sequencer and divide unit
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

  function automatic logic [15:0] sext(input logic [15:0] v, input int unsigned bits);
    logic [15:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (i >= bits) r[i] = v[bits-1];
    end
    return r;
  endfunction

  function automatic logic [2:0] nzp_of(input logic [15:0] v);
    logic [2:0] r;
    if (v == 16'd0) r = NZP_ZERO;
    else if (v[15]) r = NZP_NEG;
    else r = NZP_POS;
    return r;
  endfunction

endpackage

[src/sie_item_if.sv]
interface sie_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] instr_word;
  logic [15:0] load_addr;
  logic [15:0] load_data;
  modport source (output valid, op, instr_word, load_addr, load_data, input ready);
  modport sink (input valid, op, instr_word, load_addr, load_data, output ready);
endinterface

interface sie_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_before;
  logic        reg_we;
  logic [2:0]  reg_dest;
  logic [15:0] reg_value;
  logic        nzp_we;
  logic [2:0]  nzp_value;
  logic        data_we;
  logic [15:0] data_addr;
  logic [15:0] data_value;
  logic        invalid;
  logic        privileged;
  modport source (output valid, pc_before, reg_we, reg_dest, reg_value, nzp_we, nzp_value,
    data_we, data_addr, data_value, invalid, privileged, input ready);
  modport sink (input valid, pc_before, reg_we, reg_dest, reg_value, nzp_we, nzp_value,
    data_we, data_addr, data_value, invalid, privileged, output ready);
endinterface

[src/sixteen_bit_isa_execute_step.sv]
// execute step of a sixteen-bit processor, one instruction per item
// an accepted item goes through S_EXEC, then S_MEM for loads or S_DIV for div and mod,
// then S_OUT, then S_WAIT until the result is taken; only then is a new item accepted
// preloads are written in idle; S_DIV waits for the bit-serial divider
// reset: pc 0x8200, registers 0, nzp zero, privileged; then a clearing pass over
// the MEM_WORDS words of data memory during which no item is accepted
module sixteen_bit_isa_execute_step
  import sie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input logic clk,
  input logic rst,
  sie_in_if.sink    in_ch,
  sie_out_if.source out_ch
);
`include "sixteen_bit_isa_execute_step_defines.svh"

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MEM   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  logic [2:0]  state;
  logic [AW:0] clr_cnt;

  // architectural state
  logic [15:0] pc;
  logic [15:0] regs [8];
  logic [2:0]  cc;
  logic        priv;

  // held instruction
  logic [15:0] ins;
  logic [15:0] rs;
  logic [15:0] rt;
  logic [15:0] rd;
  logic [15:0] daddr;

  // output register
  trace_t      tr;
  logic        out_valid;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [3:0]  opc;
  logic [2:0]  fd;
  logic [15:0] npc;
  logic [15:0] alu;
  logic        rwe;
  logic [2:0]  rdst;
  logic        is_div;
  logic [15:0] cmp_b;
  logic [2:0]  cmp_cc;
  logic [15:0] sra_v;

  assign opc = ins[15:12];
  assign fd  = ins[11:9];
  assign daddr = rs + sext(ins, 6);
  assign is_div = (opc == OPC_ARITH && !ins[5] && ins[4:3] == AR_DIV) ||
                  (opc == OPC_SHIFT && ins[5:4] == SH_MOD);

  assign in_ch.ready = (state == S_IDLE);

  sie_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  sie_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign dreq.start    = (state == S_EXEC) && is_div;
  assign dreq.dividend = rs;
  assign dreq.divisor  = rt;
  assign mem_raddr     = daddr[AW-1:0];

  // memory write: clearing pass, preload, or store in the execute cycle
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = clr_cnt[AW-1:0];
    mem_wdata = 16'd0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_IDLE && in_ch.valid && in_ch.op) begin
      mem_we = 1'b1;
      mem_waddr = in_ch.load_addr[AW-1:0];
      mem_wdata = in_ch.load_data;
    end else if (state == S_EXEC && opc == OPC_STR) begin
      mem_we = 1'b1;
      mem_waddr = daddr[AW-1:0];
      mem_wdata = rd;
    end
  end

  // compare source and signed/unsigned three-way result
  always_comb begin
    cmp_b = ins[8] ? (ins[7] ? {9'd0, ins[6:0]} : sext(ins, 7)) : rt;
    if (ins[7]) begin
      cmp_cc = (rd > cmp_b) ? NZP_POS : ((rd < cmp_b) ? NZP_NEG : NZP_ZERO);
    end else begin
      cmp_cc = ($signed(rd) > $signed(cmp_b)) ? NZP_POS :
               (($signed(rd) < $signed(cmp_b)) ? NZP_NEG : NZP_ZERO);
    end
    sra_v = 16'($signed(rs) >>> ins[3:0]);
  end

  // combinational next pc and result for every opcode; load and divide results come from the memory and the divider
  always_comb begin
    npc  = pc + 16'd1;
    alu  = 16'd0;
    rwe  = 1'b0;
    rdst = fd;
    unique case (opc) inside
      OPC_BR: begin
        if ((fd & cc) != 3'd0) npc = pc + 16'd1 + sext(ins, 9);
      end
      OPC_ARITH: begin
        rwe = 1'b1;
        if (ins[5]) alu = rs + sext(ins, 5);
        else begin
          case (ins[4:3])
            AR_ADD: alu = rs + rt;
            AR_MUL: alu = 16'(rs * rt);
            AR_SUB: alu = rs - rt;
            default: alu = drsp.quot;
          endcase
        end
      end
      OPC_JSR: begin
        rwe = 1'b1; rdst = 3'd7; alu = pc + 16'd1;
        npc = ins[11] ? {pc[15], ins[10:0], 4'd0} : rs;
      end
      OPC_LOGIC: begin
        rwe = 1'b1;
        if (ins[5]) alu = rs & sext(ins, 5);
        else begin
          case (ins[4:3])
            LG_AND: alu = rs & rt;
            LG_NOT: alu = ~rs;
            LG_OR:  alu = rs | rt;
            default: alu = rs ^ rt;
          endcase
        end
      end
      OPC_LDR: begin
        rwe = 1'b1; alu = mem_rdata;
      end
      OPC_RTI: npc = regs[7];
      OPC_CONST: begin
        rwe = 1'b1; alu = sext(ins, 9);
      end
      OPC_SHIFT: begin
        rwe = 1'b1;
        case (ins[5:4])
          SH_SLL: alu = rs << ins[3:0];
          SH_SRA: alu = sra_v;
          SH_SRL: alu = rs >> ins[3:0];
          default: alu = drsp.rem;
        endcase
      end
      OPC_JMP: npc = ins[11] ? pc + 16'd1 + sext(ins, 11) : rs;
      OPC_HICON: begin
        rwe = 1'b1; alu = {ins[7:0], rd[7:0]};
      end
      OPC_TRAP: begin
        rwe = 1'b1; rdst = 3'd7; alu = pc + 16'd1;
        npc = {8'h80, ins[7:0]};
      end
      OPC_CMP, OPC_STR: ;
      default: npc = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      pc <= PC_RESET;
      cc <= NZP_ZERO;
      priv <= 1'b1;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= 16'd0;
    end else begin
      unique case (state) inside
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            if (!in_ch.op) state <= S_EXEC;
            ins <= in_ch.instr_word;
            rs  <= regs[in_ch.instr_word[8:6]];
            rt  <= regs[in_ch.instr_word[2:0]];
            rd  <= regs[in_ch.instr_word[11:9]];
          end
        end
        S_EXEC: begin
          if (is_div) state <= S_DIV;
          else if (opc == OPC_LDR) state <= S_MEM;
          else state <= S_OUT;
        end
        S_MEM, S_DIV: begin
          if (state == S_MEM || drsp.done) state <= S_OUT;
        end
        S_OUT: begin
          // commit architectural state and load the result register
          tr.pc_before  <= pc;
          tr.reg_we     <= rwe;
          tr.reg_dest   <= rwe ? rdst : 3'd0;
          tr.reg_value  <= rwe ? alu : 16'd0;
          tr.nzp_we     <= rwe || opc == OPC_CMP;
          tr.nzp_value  <= rwe ? nzp_of(alu) : (opc == OPC_CMP ? cmp_cc : 3'd0);
          tr.data_we    <= (opc == OPC_STR);
          tr.data_addr  <= (opc == OPC_STR || opc == OPC_LDR) ? daddr : 16'd0;
          tr.data_value <= (opc == OPC_STR) ? rd : (opc == OPC_LDR ? mem_rdata : 16'd0);
          tr.invalid    <= (opc == OPC_BAD3 || opc == OPC_BADB || opc == OPC_BADE);
          tr.privileged <= (opc == OPC_RTI) ? 1'b0 : ((opc == OPC_TRAP) ? 1'b1 : priv);
          if (rwe) begin
            regs[rdst] <= alu;
            cc <= nzp_of(alu);
          end else if (opc == OPC_CMP) begin
            cc <= cmp_cc;
          end
          if (opc == OPC_RTI) priv <= 1'b0;
          if (opc == OPC_TRAP) priv <= 1'b1;
          pc <= npc;
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.pc_before  = tr.pc_before;
  assign out_ch.reg_we     = tr.reg_we;
  assign out_ch.reg_dest   = tr.reg_dest;
  assign out_ch.reg_value  = tr.reg_value;
  assign out_ch.nzp_we     = tr.nzp_we;
  assign out_ch.nzp_value  = tr.nzp_value;
  assign out_ch.data_we    = tr.data_we;
  assign out_ch.data_addr  = tr.data_addr;
  assign out_ch.data_value = tr.data_value;
  assign out_ch.invalid    = tr.invalid;
  assign out_ch.privileged = tr.privileged;

  `SIE_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ch.ready,
    "item accepted outside idle")
  `SIE_ASSERT_IMP(a_valid_in_wait, clk, rst, out_valid, state == S_WAIT,
    "result valid outside wait state")
  `SIE_ASSERT_NEXT(a_div_done, clk, rst, state == S_DIV && drsp.done, state == S_OUT,
    "divide result not committed")
endmodule

[src/sie_div.sv]
module sie_div
  import sie_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  // restoring divide on magnitudes, one quotient bit per cycle
  logic        busy;
  logic        done;
  logic [3:0]  count;
  logic [15:0] q;
  logic [16:0] r;
  logic [15:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic        zero;
  logic [16:0] trial;
  logic [15:0] a_mag;
  logic [15:0] b_mag;

  assign a_mag = req.dividend[15] ? 16'(-req.dividend) : req.dividend;
  assign b_mag = req.divisor[15] ? 16'(-req.divisor) : req.divisor;
  assign trial = {r[15:0], q[15]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 4'd15;
      end else if (busy) begin
        if (count == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q <= a_mag;
      r <= 17'd0;
      dvs <= b_mag;
      neg_q <= req.dividend[15] ^ req.divisor[15];
      neg_r <= req.dividend[15];
      zero <= (req.divisor == 16'd0);
    end else if (busy) begin
      if (!trial[16]) begin
        r <= trial;
        q <= {q[14:0], 1'b1};
      end else begin
        r <= {r[15:0], q[15]};
        q <= {q[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quot = zero ? 16'd0 : (neg_q ? 16'(-q) : q);
    rsp.rem  = zero ? 16'd0 : (neg_r ? 16'(-r[15:0]) : r[15:0]);
  end
endmodule

[src/sie_dmem.sv]
module sie_dmem
  import sie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MEM_WORDS)-1:0] waddr,
  input  logic [15:0]                  wdata,
  input  logic [$clog2(MEM_WORDS)-1:0] raddr,
  output logic [15:0]                  rdata
);
  logic [15:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
